// ===== design/tccw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_pkg: shared types and constants of the text cell console writer
// Geometry limits, field widths, function codes, the decoded command that
// travels from front to back, and the result record.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // Store geometry
  localparam int unsigned MAX_COLS = 128;
  localparam int unsigned MAX_ROWS = 64;
  localparam int unsigned DEPTH    = MAX_COLS * MAX_ROWS;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned COL_W    = $clog2(MAX_COLS);
  localparam int unsigned ROW_W    = $clog2(MAX_ROWS);
  localparam int unsigned CNTC_W   = $clog2(MAX_COLS + 1);
  localparam int unsigned CNTR_W   = $clog2(MAX_ROWS + 1);

  // Field widths of the stream items and registers
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned TC_W     = 7;
  localparam int unsigned TR_W     = 6;
  localparam int unsigned CFGC_W   = 8;
  localparam int unsigned CFGR_W   = 7;
  localparam int unsigned CFGD_W   = 8;

  // Widths of the cursor placement arithmetic (room for one step past the end)
  localparam int unsigned PX_W = ((CNTC_W > TC_W) ? CNTC_W : TC_W) + 1;
  localparam int unsigned PY_W = ((CNTR_W > TR_W) ? CNTR_W : TR_W) + 1;

  // Command queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_BACKSPACE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_MOVE      = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd4;

  // Register indexes
  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_WRITE,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_CLEAR,
    OP_MOVE,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] char_code;
    logic [TC_W-1:0]   target_col;
    logic [TR_W-1:0]   target_row;
  } cmd_t;

  typedef struct packed {
    logic              did_scroll;
    logic              char_accepted;
    logic [CHAR_W-1:0] cell_value;
    logic [TR_W-1:0]   cursor_row;
    logic [TC_W-1:0]   cursor_col;
  } res_t;

endpackage
`default_nettype wire

// ===== design/text_cell_console_writer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_cell_console_writer_core: character-cell console store with a cursor
// Classify stream commands, queue them, and execute them on a cell store.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per transaction (write char, backspace, clear,
//   move cursor, read cell); m_axis returns exactly one result per command
//   with the cursor after the operation, the cell read, and status flags.
//   The cfg channel writes columns_in_use (index 0) and rows_in_use (index 1);
//   write it only while no command is in flight. cfg_ready_o is always high.
// Operation:
//   Write, newline, backspace, move and unused codes finish in the idle
//   state; the back end takes no new command while a result is held in
//   the output register. A read passes through the registered RAM port.
//   A scroll copies the rows in use over the full row stride, one
//   cell per cycle, then fills the new bottom row. Clear sweeps all 8192
//   cells. All of this work goes through the single RAM write port.
// Reset:
//   Cursor goes to 0,0, registers to 80 columns and 25 rows, and a clearing
//   pass zeroes the store; s_axis_tready stays low meanwhile.
// Stalls:
//   When m_axis_tready is low the result holds and the back end waits; the
//   two-entry command queue keeps taking transactions until it fills.
// ----------------------------------------------------------------------------
module text_cell_console_writer_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // s_axis_tdata: func[2:0], char_code[10:3], target_col[17:11], target_row[23:18]
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [23:0]                  s_axis_tdata,
  // m_axis_tdata: cursor_col[6:0], cursor_row[12:7], cell_value[20:13],
  //               char_accepted[21], did_scroll[22], zero[23]
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [23:0]                       m_axis_tdata,
  // Configuration write channel
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic                         cfg_index_i,
  input  wire logic [tccw_pkg::CFGD_W-1:0]  cfg_data_i
);

  logic [tccw_pkg::CFGC_W-1:0] cols_q;
  logic [tccw_pkg::CFGR_W-1:0] rows_q;

  logic           push_valid, push_ready;
  tccw_pkg::cmd_t push_cmd, head_cmd;
  logic           head_valid, head_pop;
  logic           init_busy;
  tccw_pkg::res_t res;

  // Configuration registers: always ready, take the data on a transaction
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= tccw_pkg::CFGC_W'(80);
      rows_q <= tccw_pkg::CFGR_W'(25);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tccw_pkg::CFG_COLUMNS: cols_q <= cfg_data_i[tccw_pkg::CFGC_W-1:0];
        tccw_pkg::CFG_ROWS:    rows_q <= cfg_data_i[tccw_pkg::CFGR_W-1:0];
        default:               ;
      endcase
    end
  end

  // Front: decode the incoming transaction into a command
  tccw_front u_front (
    .tvalid_i    (s_axis_tvalid),
    .tready_o    (s_axis_tready),
    .tdata_i     (s_axis_tdata),
    .init_busy_i (init_busy),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_cmd_o  (push_cmd)
  );

  // Queue: decouple front and back
  tccw_cmd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_cmd_i  (push_cmd),
    .pop_valid_o (head_valid),
    .pop_ready_i (head_pop),
    .pop_cmd_o   (head_cmd)
  );

  // Back: execute on the cursor and the cell store
  tccw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_cols_i (cols_q),
    .cfg_rows_i (rows_q),
    .q_valid_i  (head_valid),
    .q_pop_o    (head_pop),
    .q_cmd_i    (head_cmd),
    .init_busy_o(init_busy),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_res_o  (res)
  );

  // Pack the result, lowest field first, pad to whole bytes
  assign m_axis_tdata = {1'b0, res.did_scroll, res.char_accepted, res.cell_value,
                         res.cursor_row, res.cursor_col};

endmodule
`default_nettype wire

// ===== design/tccw_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tccw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== design/tccw_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_front: input classifier
// Unpack an input transaction and decode it into a command for the back end.
// ----------------------------------------------------------------------------
module tccw_front (
  input  wire logic                          tvalid_i,
  output logic                               tready_o,
  input  wire logic [23:0]                   tdata_i,
  input  wire logic                          init_busy_i,
  output logic                               push_valid_o,
  input  wire logic                          push_ready_i,
  output tccw_pkg::cmd_t                     push_cmd_o
);

  logic [tccw_pkg::FUNC_W-1:0] func;
  logic [tccw_pkg::CHAR_W-1:0] ch;
  logic                        printable;

  assign func = tdata_i[2:0];
  assign ch   = tdata_i[10:3];

  // Hold off input during the clearing pass after reset
  assign tready_o     = push_ready_i && !init_busy_i;
  assign push_valid_o = tvalid_i && !init_busy_i;

  assign printable = (ch == tccw_pkg::CH_TAB) || (ch == tccw_pkg::CH_LF) ||
                     (ch == tccw_pkg::CH_CR) ||
                     ((ch >= tccw_pkg::CH_SPACE) && (ch <= tccw_pkg::CH_TILDE));

  always_comb begin
    push_cmd_o.char_code  = ch;
    push_cmd_o.target_col = tdata_i[17:11];
    push_cmd_o.target_row = tdata_i[23:18];
    unique case (func)
      tccw_pkg::FUNC_WRITE: begin
        if (!printable) begin
          push_cmd_o.op = tccw_pkg::OP_NOP;
        end else if (ch == tccw_pkg::CH_LF) begin
          push_cmd_o.op = tccw_pkg::OP_NEWLINE;
        end else begin
          push_cmd_o.op = tccw_pkg::OP_WRITE;
        end
      end
      tccw_pkg::FUNC_BACKSPACE: push_cmd_o.op = tccw_pkg::OP_BACKSPACE;
      tccw_pkg::FUNC_CLEAR:     push_cmd_o.op = tccw_pkg::OP_CLEAR;
      tccw_pkg::FUNC_MOVE:      push_cmd_o.op = tccw_pkg::OP_MOVE;
      tccw_pkg::FUNC_READ:      push_cmd_o.op = tccw_pkg::OP_READ;
      default:                  push_cmd_o.op = tccw_pkg::OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/tccw_cmd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_cmd_queue: short command queue
// Decouple the classifier from the executing back end.
// ----------------------------------------------------------------------------
module tccw_cmd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire tccw_pkg::cmd_t push_cmd_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output tccw_pkg::cmd_t      pop_cmd_o
);

  tccw_pkg::cmd_t                ent_q [tccw_pkg::QUEUE_DEPTH];
  logic [tccw_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [tccw_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [tccw_pkg::QCNT_W-1:0]   cnt_q, cnt_d;
  logic                          push, pop;

  assign push_ready_o = (cnt_q != tccw_pkg::QCNT_W'(tccw_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = ent_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == tccw_pkg::QPTR_W'(tccw_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + tccw_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == tccw_pkg::QPTR_W'(tccw_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + tccw_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + tccw_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - tccw_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/tccw_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_back: command executor
// Own the cursor and the cell store; run writes, scrolls, clears and reads
// and hold each result in an output register.
// ----------------------------------------------------------------------------
module tccw_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [tccw_pkg::CFGC_W-1:0]   cfg_cols_i,
  input  wire logic [tccw_pkg::CFGR_W-1:0]   cfg_rows_i,
  input  wire logic                          q_valid_i,
  output logic                               q_pop_o,
  input  wire tccw_pkg::cmd_t                q_cmd_i,
  output logic                               init_busy_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output tccw_pkg::res_t                     out_res_o
);

  localparam int unsigned COL_W  = tccw_pkg::COL_W;
  localparam int unsigned ROW_W  = tccw_pkg::ROW_W;
  localparam int unsigned CNTC_W = tccw_pkg::CNTC_W;
  localparam int unsigned CNTR_W = tccw_pkg::CNTR_W;
  localparam int unsigned ADDR_W = tccw_pkg::ADDR_W;
  localparam int unsigned PX_W   = tccw_pkg::PX_W;
  localparam int unsigned PY_W   = tccw_pkg::PY_W;
  localparam int unsigned CHAR_W = tccw_pkg::CHAR_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FILL  = 3'd4;
  localparam logic [2:0] ST_CLEAR = 3'd5;

  function automatic logic [ADDR_W-1:0] cell_addr(input int unsigned r,
                                                  input int unsigned c);
    return ADDR_W'(r * tccw_pkg::MAX_COLS + c);
  endfunction

  logic [2:0]        state_q, state_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic              acc_q, acc_d;
  logic              emit_q, emit_d;
  logic              rdok_q, rdok_d;
  logic [ADDR_W-1:0] src_q, src_d;
  logic [COL_W-1:0]  fill_q, fill_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              wr_v_q, wr_v_d;
  logic [ADDR_W-1:0] wr_addr_q, wr_addr_d;
  logic              out_valid_q, out_valid_d;
  tccw_pkg::res_t    out_q, res;
  logic              load;

  logic [CNTC_W-1:0] cols;
  logic [CNTR_W-1:0] rows;
  logic [COL_W-1:0]  cx, bs_col, pcol;
  logic [ROW_W-1:0]  cy, bs_row, prow;
  logic [PX_W-1:0]   px, pxw;
  logic [PY_W-1:0]   py, pyw;
  logic              wrap, scroll, rd_ok;
  logic [ADDR_W-1:0] shift_last, fill_base;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  // Effective geometry from the registers
  always_comb begin
    if (cfg_cols_i == '0) begin
      cols = CNTC_W'(1);
    end else if (32'(cfg_cols_i) > tccw_pkg::MAX_COLS) begin
      cols = CNTC_W'(tccw_pkg::MAX_COLS);
    end else begin
      cols = CNTC_W'(cfg_cols_i);
    end
    if (cfg_rows_i == '0) begin
      rows = CNTR_W'(1);
    end else if (32'(cfg_rows_i) > tccw_pkg::MAX_ROWS) begin
      rows = CNTR_W'(tccw_pkg::MAX_ROWS);
    end else begin
      rows = CNTR_W'(cfg_rows_i);
    end
  end

  assign shift_last = ADDR_W'(32'(rows) * tccw_pkg::MAX_COLS - 1);
  assign fill_base  = cell_addr(32'(rows) - 1, 0);

  // Clamp the cursor into the area in use
  assign cx = (CNTC_W'(cur_col_q) >= cols) ? COL_W'(cols - CNTC_W'(1)) : cur_col_q;
  assign cy = (CNTR_W'(cur_row_q) >= rows) ? ROW_W'(rows - CNTR_W'(1)) : cur_row_q;

  // Backspace position
  always_comb begin
    if (cx != '0) begin
      bs_col = cx - COL_W'(1);
      bs_row = cy;
    end else if (cy != '0) begin
      bs_col = COL_W'(cols - CNTC_W'(1));
      bs_row = cy - ROW_W'(1);
    end else begin
      bs_col = '0;
      bs_row = '0;
    end
  end

  // Cursor placement with column wrap and scroll detect
  always_comb begin
    unique case (q_cmd_i.op)
      tccw_pkg::OP_NEWLINE: begin
        px = '0;
        py = PY_W'(cy) + PY_W'(1);
      end
      tccw_pkg::OP_MOVE: begin
        px = PX_W'(q_cmd_i.target_col);
        py = PY_W'(q_cmd_i.target_row);
      end
      default: begin
        px = PX_W'(cx) + PX_W'(1);
        py = PY_W'(cy);
      end
    endcase
    wrap   = (px >= PX_W'(cols));
    pxw    = wrap ? '0 : px;
    pyw    = wrap ? py + PY_W'(1) : py;
    scroll = (pyw >= PY_W'(rows));
    prow   = scroll ? ROW_W'(rows - CNTR_W'(1)) : ROW_W'(pyw);
    pcol   = COL_W'(pxw);
  end

  assign rd_ok = (32'(q_cmd_i.target_col) < tccw_pkg::MAX_COLS) &&
                 (32'(q_cmd_i.target_row) < tccw_pkg::MAX_ROWS);

  always_comb begin
    state_d   = state_q;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    acc_d     = acc_q;
    emit_d    = emit_q;
    rdok_d    = rdok_q;
    src_d     = src_q;
    fill_d    = fill_q;
    clr_d     = clr_q;
    wr_v_d    = 1'b0;
    wr_addr_d = wr_addr_q;
    q_pop_o   = 1'b0;
    load      = 1'b0;
    res       = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && !out_valid_q) begin
          q_pop_o   = 1'b1;
          cur_col_d = cx;
          cur_row_d = cy;
          unique case (q_cmd_i.op)
            tccw_pkg::OP_WRITE, tccw_pkg::OP_NEWLINE, tccw_pkg::OP_MOVE: begin
              if (q_cmd_i.op == tccw_pkg::OP_WRITE) begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr(32'(cy), 32'(cx));
                ram_wdata = q_cmd_i.char_code;
              end
              cur_col_d = pcol;
              cur_row_d = prow;
              acc_d     = (q_cmd_i.op != tccw_pkg::OP_MOVE);
              if (scroll) begin
                src_d   = ADDR_W'(tccw_pkg::MAX_COLS);
                fill_d  = '0;
                state_d = (rows > CNTR_W'(1)) ? ST_SHIFT : ST_FILL;
              end else begin
                load              = 1'b1;
                res.char_accepted = acc_d;
              end
            end
            tccw_pkg::OP_BACKSPACE: begin
              ram_we    = 1'b1;
              ram_waddr = cell_addr(32'(bs_row), 32'(bs_col));
              ram_wdata = tccw_pkg::CH_SPACE;
              cur_col_d = bs_col;
              cur_row_d = bs_row;
              load      = 1'b1;
            end
            tccw_pkg::OP_CLEAR: begin
              clr_d   = '0;
              emit_d  = 1'b1;
              state_d = ST_CLEAR;
            end
            tccw_pkg::OP_READ: begin
              ram_re    = rd_ok;
              ram_raddr = cell_addr(32'(q_cmd_i.target_row), 32'(q_cmd_i.target_col));
              rdok_d    = rd_ok;
              state_d   = ST_READ;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        load           = 1'b1;
        res.cell_value = rdok_q ? ram_rdata : '0;
        state_d        = ST_IDLE;
      end
      ST_SHIFT: begin
        // Read one row down, write it back one row up in the next cycle
        ram_re    = 1'b1;
        ram_raddr = src_q;
        wr_v_d    = 1'b1;
        wr_addr_d = src_q - ADDR_W'(tccw_pkg::MAX_COLS);
        if (src_q == shift_last) begin
          state_d = ST_DRAIN;
        end else begin
          src_d = src_q + ADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        fill_d  = '0;
        state_d = ST_FILL;
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_base + ADDR_W'(fill_q);
        ram_wdata = (CNTC_W'(fill_q) < cols) ? tccw_pkg::CH_SPACE : '0;
        if (fill_q == COL_W'(tccw_pkg::MAX_COLS - 1)) begin
          load              = 1'b1;
          res.char_accepted = acc_q;
          res.did_scroll    = 1'b1;
          state_d           = ST_IDLE;
        end else begin
          fill_d = fill_q + COL_W'(1);
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == ADDR_W'(tccw_pkg::DEPTH - 1)) begin
          load    = emit_q;
          emit_d  = 1'b0;
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + ADDR_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Delayed half of the row copy
    if (wr_v_q) begin
      ram_we    = 1'b1;
      ram_waddr = wr_addr_q;
      ram_wdata = ram_rdata;
    end

    res.cursor_col = tccw_pkg::TC_W'(cur_col_d);
    res.cursor_row = tccw_pkg::TR_W'(cur_row_d);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      acc_q       <= 1'b0;
      emit_q      <= 1'b0;
      rdok_q      <= 1'b0;
      src_q       <= '0;
      fill_q      <= '0;
      clr_q       <= '0;
      wr_v_q      <= 1'b0;
      wr_addr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      acc_q       <= acc_d;
      emit_q      <= emit_d;
      rdok_q      <= rdok_d;
      src_q       <= src_d;
      fill_q      <= fill_d;
      clr_q       <= clr_d;
      wr_v_q      <= wr_v_d;
      wr_addr_q   <= wr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  tccw_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(tccw_pkg::DEPTH)
  ) u_cells (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign init_busy_o = (state_q == ST_CLEAR) && !emit_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  a_pop_needs_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !out_valid_q)
    else $error("command popped while a result is still held");

  a_scroll_ends_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && res.did_scroll) |-> (state_q == ST_FILL))
    else $error("scroll result issued outside the fill phase");

  a_copy_only_in_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_v_q |-> (state_q == ST_SHIFT || state_q == ST_DRAIN))
    else $error("row copy write outside the shift phase");

  a_cursor_in_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> ((CNTC_W'(cur_col_q) < $past(cols)) && (CNTR_W'(cur_row_q) < $past(rows))))
    else $error("cursor left the area in use");

endmodule
`default_nettype wire

// ===== tb/text_cell_console_writer_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_cell_console_writer_core_tb: self-checking bench for the console store
// Drive console commands over s_axis and mirror each one in a cycle-free
// model of the cell store and cursor, then compare every m_axis result field
// by field. A short table of hand-picked commands runs first, followed by
// random phases under several screen geometries and idle/stall patterns.
// ----------------------------------------------------------------------------
module text_cell_console_writer_core_tb;

  localparam int unsigned MAX_COLS = tccw_pkg::MAX_COLS;
  localparam int unsigned MAX_ROWS = tccw_pkg::MAX_ROWS;
  localparam int unsigned DEPTH    = tccw_pkg::DEPTH;
  localparam int unsigned ADDR_W   = tccw_pkg::ADDR_W;
  localparam int unsigned FUNC_W   = tccw_pkg::FUNC_W;
  localparam int unsigned CHAR_W   = tccw_pkg::CHAR_W;
  localparam int unsigned TC_W     = tccw_pkg::TC_W;
  localparam int unsigned TR_W     = tccw_pkg::TR_W;
  localparam int unsigned CFGC_W   = tccw_pkg::CFGC_W;
  localparam int unsigned CFGR_W   = tccw_pkg::CFGR_W;
  localparam int unsigned CFGD_W   = tccw_pkg::CFGD_W;

  // Spare function codes, expected to change nothing.
  localparam logic [FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

  // Give up well past the slowest expected run (clear sweeps dominate).
  localparam int unsigned CYCLE_LIMIT = 2000000;
  // Quiet time before a register write and at the end of the run.
  localparam int unsigned SETTLE_CYCLES = 12;

  // Expected-result ring and directed table sizes.
  localparam int unsigned EXP_DEPTH = 2048;
  localparam int unsigned EXP_W     = $clog2(EXP_DEPTH);
  localparam int unsigned DIR_MAX   = 32;
  localparam int unsigned DIR_W     = $clog2(DIR_MAX);

  // One row of the directed table: command fields, and a hand-typed result
  // where the outcome is obvious; other rows fall back on the model.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] code;
    logic [TC_W-1:0]   tc;
    logic [TR_W-1:0]   tr;
    logic              typed;
    tccw_pkg::res_t    want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [CFGD_W-1:0] cfg_data_i;

  // Model state: store, cursor and the two geometry registers.
  logic [CHAR_W-1:0] screen_mem [0:DEPTH-1];
  int unsigned       cur_x;
  int unsigned       cur_y;
  logic [CFGC_W-1:0] cols_reg;
  logic [CFGR_W-1:0] rows_reg;

  // Expected results in send order: written by the sender, read by the checker.
  tccw_pkg::res_t exp_buf [EXP_DEPTH];
  int unsigned    exp_wr;
  int unsigned    exp_rd;
  dir_row_t       dir_tab [DIR_MAX];
  int unsigned    dir_count;
  int unsigned    mismatches;
  int unsigned    cycle_count;
  int unsigned    gap_pct;
  int unsigned    stall_pct;

  text_cell_console_writer_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Console model
  // --------------------------------------------------------------------------

  function automatic logic [ADDR_W-1:0] scr_idx(int unsigned x, int unsigned y);
    return ADDR_W'(y * MAX_COLS + x);
  endfunction

  // Clamp the register values into the usable geometry.
  function automatic int unsigned cols_active();
    if (cols_reg == '0) return 1;
    if (32'(cols_reg) > MAX_COLS) return MAX_COLS;
    return 32'(cols_reg);
  endfunction

  function automatic int unsigned rows_active();
    if (rows_reg == '0) return 1;
    if (32'(rows_reg) > MAX_ROWS) return MAX_ROWS;
    return 32'(rows_reg);
  endfunction

  function automatic bit is_accepted_code(logic [CHAR_W-1:0] c);
    return c == tccw_pkg::CH_TAB || c == tccw_pkg::CH_LF || c == tccw_pkg::CH_CR ||
           (c >= tccw_pkg::CH_SPACE && c <= tccw_pkg::CH_TILDE);
  endfunction

  // Shift the rows in use up by one full stride; blank the new bottom row
  // with spaces inside the columns in use and zeros past them.
  function automatic void scroll_screen(int unsigned cols, int unsigned rows);
    int unsigned i;
    for (i = 0; i < (rows - 1) * MAX_COLS; i++)
      screen_mem[ADDR_W'(i)] = screen_mem[ADDR_W'(i + MAX_COLS)];
    for (i = 0; i < MAX_COLS; i++)
      screen_mem[scr_idx(i, rows - 1)] = (i < cols) ? tccw_pkg::CH_SPACE : '0;
  endfunction

  // Put the cursor at x,y with column wrap; scroll when it leaves the area.
  function automatic bit place_cursor(int unsigned x, int unsigned y,
                                      int unsigned cols, int unsigned rows);
    bit scrolled;
    scrolled = 1'b0;
    if (x >= cols) begin
      x = 0;
      y++;
    end
    if (y >= rows) begin
      scroll_screen(cols, rows);
      y = rows - 1;
      scrolled = 1'b1;
    end
    cur_x = x;
    cur_y = y;
    return scrolled;
  endfunction

  // Apply one command to the model and return the result it must produce.
  function automatic tccw_pkg::res_t apply_console_op(logic [23:0] word);
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] code;
    int unsigned       tc;
    int unsigned       tr;
    int unsigned       cols;
    int unsigned       rows;
    tccw_pkg::res_t    r;
    func = word[2:0];
    code = word[10:3];
    tc   = 32'(word[17:11]);
    tr   = 32'(word[23:18]);
    cols = cols_active();
    rows = rows_active();
    r    = '0;
    // A shrunk geometry may leave the cursor outside; pull it back in first.
    if (cur_x >= cols) cur_x = cols - 1;
    if (cur_y >= rows) cur_y = rows - 1;
    case (func)
      tccw_pkg::FUNC_WRITE: begin
        if (is_accepted_code(code)) begin
          r.char_accepted = 1'b1;
          if (code == tccw_pkg::CH_LF) begin
            r.did_scroll = place_cursor(0, cur_y + 1, cols, rows);
          end else begin
            screen_mem[scr_idx(cur_x, cur_y)] = code;
            r.did_scroll = place_cursor(cur_x + 1, cur_y, cols, rows);
          end
        end
      end
      tccw_pkg::FUNC_BACKSPACE: begin
        if (cur_x > 0) begin
          cur_x--;
        end else if (cur_y > 0) begin
          cur_x = cols - 1;
          cur_y--;
        end
        screen_mem[scr_idx(cur_x, cur_y)] = tccw_pkg::CH_SPACE;
      end
      tccw_pkg::FUNC_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) screen_mem[ADDR_W'(i)] = '0;
      end
      tccw_pkg::FUNC_MOVE: begin
        r.did_scroll = place_cursor(tc, tr, cols, rows);
      end
      tccw_pkg::FUNC_READ: begin
        r.cell_value = screen_mem[scr_idx(tc, tr)];
      end
      default: begin
      end
    endcase
    r.cursor_col = cur_x[TC_W-1:0];
    r.cursor_row = cur_y[TR_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers (all called and returning at a falling edge)
  // --------------------------------------------------------------------------

  function automatic logic [23:0] pack_cmd(logic [FUNC_W-1:0] func, logic [CHAR_W-1:0] code,
                                           logic [TC_W-1:0] tc, logic [TR_W-1:0] tr);
    return {tr, tc, code, func};
  endfunction

  // Append one row to the directed table.
  task automatic add_row(logic [FUNC_W-1:0] func, logic [CHAR_W-1:0] code,
                         int unsigned tc, int unsigned tr, bit typed,
                         int unsigned col, int unsigned rw, int unsigned cell_val,
                         bit acc, bit scr);
    dir_row_t d;
    d.func  = func;
    d.code  = code;
    d.tc    = TC_W'(tc);
    d.tr    = TR_W'(tr);
    d.typed = typed;
    d.want.cursor_col    = TC_W'(col);
    d.want.cursor_row    = TR_W'(rw);
    d.want.cell_value    = CHAR_W'(cell_val);
    d.want.char_accepted = acc;
    d.want.did_scroll    = scr;
    dir_tab[dir_count[DIR_W-1:0]] = d;
    dir_count++;
  endtask

  // Send one command; on acceptance advance the model and record the result.
  // A typed result, when given, replaces the model's answer as expectation.
  task automatic send_cmd(logic [23:0] word, bit typed, tccw_pkg::res_t typed_res);
    tccw_pkg::res_t modeled;
    // Idle the sender for a random stretch in the gap-heavy phases.
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    modeled = apply_console_op(word);
    exp_buf[exp_wr[EXP_W-1:0]] = typed ? typed_res : modeled;
    exp_wr++;
    @(negedge clk_i);
  endtask

  // Hold until every result is back and the core has gone quiet.
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (exp_wr != exp_rd) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CFGD_W-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == tccw_pkg::CFG_COLUMNS) cols_reg = data;
    else rows_reg = data[CFGR_W-1:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Pick a byte for a write: mostly the accepted set, some raw noise.
  // Line feeds are rarer on tall screens where a scroll is expensive.
  function automatic logic [CHAR_W-1:0] pick_code(bit tall);
    int unsigned k;
    int unsigned lf_pct;
    k = $urandom_range(99);
    lf_pct = tall ? 2 : 15;
    if (k < 25) return CHAR_W'($urandom_range(255));
    if (k < 25 + lf_pct) return tccw_pkg::CH_LF;
    if (k < 31 + lf_pct) return $urandom_range(1) ? tccw_pkg::CH_TAB : tccw_pkg::CH_CR;
    return CHAR_W'($urandom_range(tccw_pkg::CH_TILDE, tccw_pkg::CH_SPACE));
  endfunction

  // Build one random command shaped by the current geometry.
  function automatic logic [23:0] random_cmd();
    int unsigned cols;
    int unsigned rows;
    int unsigned k;
    bit          tall;
    int unsigned tc;
    int unsigned tr;
    cols = cols_active();
    rows = rows_active();
    tall = rows > 8;
    k    = $urandom_range(99);
    if (k < 55) return pack_cmd(tccw_pkg::FUNC_WRITE, pick_code(tall),
                                TC_W'($urandom_range(127)), TR_W'($urandom_range(63)));
    if (k < 65) return pack_cmd(tccw_pkg::FUNC_BACKSPACE, CHAR_W'($urandom_range(255)),
                                TC_W'($urandom_range(127)), TR_W'($urandom_range(63)));
    if (k < 66) return pack_cmd(tccw_pkg::FUNC_CLEAR, CHAR_W'($urandom_range(255)),
                                TC_W'($urandom_range(127)), TR_W'($urandom_range(63)));
    if (k < 78) begin
      // Reach one past the last column so the wrap-to-next-row move shows up.
      tc = $urandom_range((cols > 127) ? 127 : cols);
      if ($urandom_range(3) == 0) tc = $urandom_range(127);
      // On tall screens keep most moves inside to bound the scroll cost.
      if (tall && $urandom_range(9) != 0) tr = $urandom_range(rows - 1);
      else tr = $urandom_range(63);
      return pack_cmd(tccw_pkg::FUNC_MOVE, CHAR_W'($urandom_range(255)), TC_W'(tc),
                      TR_W'(tr));
    end
    if (k < 94) begin
      if ($urandom_range(3) == 0) begin
        tc = $urandom_range(127);
        tr = $urandom_range(63);
      end else begin
        tc = $urandom_range(cols - 1);
        tr = $urandom_range(rows - 1);
      end
      return pack_cmd(tccw_pkg::FUNC_READ, CHAR_W'($urandom_range(255)), TC_W'(tc),
                      TR_W'(tr));
    end
    // Unused function codes with random payload.
    return pack_cmd(FUNC_W'($urandom_range(FUNC_SPARE_7, FUNC_SPARE_5)),
                    CHAR_W'($urandom_range(255)), TC_W'($urandom_range(127)),
                    TR_W'($urandom_range(63)));
  endfunction

  // Retune geometry and idling, then run a batch of random commands.
  task automatic run_phase(logic [CFGD_W-1:0] cols_val, logic [CFGD_W-1:0] rows_val,
                           int unsigned gap, int unsigned stall, int unsigned count);
    drain_results();
    write_reg(tccw_pkg::CFG_COLUMNS, cols_val);
    write_reg(tccw_pkg::CFG_ROWS, rows_val);
    gap_pct   = gap;
    stall_pct = stall;
    repeat (count) send_cmd(random_cmd(), 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // Randomly stall the result stream at the configured rate.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin : check_result
      tccw_pkg::res_t got;
      tccw_pkg::res_t want;
      got = m_axis_tdata[$bits(tccw_pkg::res_t)-1:0];
      if (exp_wr == exp_rd) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing pending: %h at %0t", m_axis_tdata, $realtime);
      end else begin
        want = exp_buf[exp_rd[EXP_W-1:0]];
        exp_rd++;
        if (got.cursor_col !== want.cursor_col || got.cursor_row !== want.cursor_row ||
            got.cell_value !== want.cell_value || got.char_accepted !== want.char_accepted ||
            got.did_scroll !== want.did_scroll) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at %0t: want col=%0d row=%0d cell=%h acc=%b scr=%b,",
                      " got col=%0d row=%0d cell=%h acc=%b scr=%b"},
                     $realtime, want.cursor_col, want.cursor_row, want.cell_value,
                     want.char_accepted, want.did_scroll, got.cursor_col, got.cursor_row,
                     got.cell_value, got.char_accepted, got.did_scroll);
        end
      end
    end
  end

  // Watchdog: bail out if the run hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL text_cell_console_writer_core");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = tccw_pkg::CFG_COLUMNS;
    cfg_data_i    = '0;
    exp_wr        = 0;
    dir_count     = 0;
    gap_pct       = 0;
    stall_pct     = 0;
    // Model reset: empty store, cursor home, 80 x 25.
    for (int i = 0; i < DEPTH; i++) screen_mem[ADDR_W'(i)] = '0;
    cur_x    = 0;
    cur_y    = 0;
    cols_reg = 8'd80;
    rows_reg = 7'd25;

    // Directed table at the reset geometry (80 x 25), walked below.
    // Reads of an untouched store, both field extremes.
    add_row(tccw_pkg::FUNC_READ, 8'h00, 0, 0, 1, 0, 0, 8'h00, 0, 0);
    add_row(tccw_pkg::FUNC_READ, 8'hFF, 127, 63, 1, 0, 0, 8'h00, 0, 0);
    // Accepted byte advances; rejected bytes around the printable range do not.
    add_row(tccw_pkg::FUNC_WRITE, 8'h41, 0, 0, 1, 1, 0, 8'h00, 1, 0);
    add_row(tccw_pkg::FUNC_WRITE, 8'h00, 0, 0, 1, 1, 0, 8'h00, 0, 0);
    add_row(tccw_pkg::FUNC_WRITE, 8'hFF, 0, 0, 1, 1, 0, 8'h00, 0, 0);
    add_row(tccw_pkg::FUNC_WRITE, 8'h7F, 0, 0, 1, 1, 0, 8'h00, 0, 0);
    add_row(tccw_pkg::FUNC_WRITE, 8'h1F, 0, 0, 1, 1, 0, 8'h00, 0, 0);
    // Tab and carriage return are stored like printable bytes.
    add_row(tccw_pkg::FUNC_WRITE, tccw_pkg::CH_TAB, 0, 0, 1, 2, 0, 8'h00, 1, 0);
    add_row(tccw_pkg::FUNC_WRITE, tccw_pkg::CH_CR, 0, 0, 1, 3, 0, 8'h00, 1, 0);
    add_row(tccw_pkg::FUNC_WRITE, tccw_pkg::CH_SPACE, 0, 0, 1, 4, 0, 8'h00, 1, 0);
    add_row(tccw_pkg::FUNC_WRITE, tccw_pkg::CH_TILDE, 0, 0, 1, 5, 0, 8'h00, 1, 0);
    add_row(tccw_pkg::FUNC_READ, 8'h00, 1, 0, 1, 5, 0, tccw_pkg::CH_TAB, 0, 0);
    add_row(tccw_pkg::FUNC_READ, 8'h00, 4, 0, 0, 0, 0, 8'h00, 0, 0);
    // Line feed, then backspace wraps to the last column of the row above.
    add_row(tccw_pkg::FUNC_WRITE, tccw_pkg::CH_LF, 0, 0, 1, 0, 1, 8'h00, 1, 0);
    add_row(tccw_pkg::FUNC_BACKSPACE, 8'h00, 0, 0, 1, 79, 0, 8'h00, 0, 0);
    add_row(tccw_pkg::FUNC_READ, 8'h00, 79, 0, 1, 79, 0, tccw_pkg::CH_SPACE, 0, 0);
    // Write in the last column wraps; a move past the column limit wraps too.
    add_row(tccw_pkg::FUNC_WRITE, 8'h5A, 0, 0, 1, 0, 1, 8'h00, 1, 0);
    add_row(tccw_pkg::FUNC_MOVE, 8'h00, 127, 0, 1, 0, 1, 8'h00, 0, 0);
    // Move below the last row scrolls once; bottom row is spaces then zeros.
    add_row(tccw_pkg::FUNC_MOVE, 8'h00, 5, 63, 1, 5, 24, 8'h00, 0, 1);
    add_row(tccw_pkg::FUNC_READ, 8'h00, 0, 24, 1, 5, 24, tccw_pkg::CH_SPACE, 0, 0);
    add_row(tccw_pkg::FUNC_READ, 8'h00, 100, 24, 1, 5, 24, 8'h00, 0, 0);
    add_row(tccw_pkg::FUNC_READ, 8'h00, 79, 0, 0, 0, 0, 8'h00, 0, 0);
    // Backspace at the top-left corner stays put and blanks the cell.
    add_row(tccw_pkg::FUNC_MOVE, 8'h00, 0, 0, 1, 0, 0, 8'h00, 0, 0);
    add_row(tccw_pkg::FUNC_BACKSPACE, 8'h00, 0, 0, 1, 0, 0, 8'h00, 0, 0);
    add_row(tccw_pkg::FUNC_READ, 8'h00, 0, 0, 1, 0, 0, tccw_pkg::CH_SPACE, 0, 0);
    // Unused codes change nothing.
    add_row(FUNC_SPARE_5, 8'hFF, 127, 63, 1, 0, 0, 8'h00, 0, 0);
    add_row(FUNC_SPARE_7, 8'h41, 7, 7, 1, 0, 0, 8'h00, 0, 0);
    // Clear keeps the cursor and empties the store.
    add_row(tccw_pkg::FUNC_CLEAR, 8'h00, 0, 0, 1, 0, 0, 8'h00, 0, 0);
    add_row(tccw_pkg::FUNC_READ, 8'h00, 0, 24, 1, 0, 0, 8'h00, 0, 0);

    // Hold reset, then release it on a falling edge.
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the table; the core's clearing pass just delays the first accept.
    for (int i = 0; i < dir_count; i++)
      send_cmd(pack_cmd(dir_tab[DIR_W'(i)].func, dir_tab[DIR_W'(i)].code,
                        dir_tab[DIR_W'(i)].tc, dir_tab[DIR_W'(i)].tr),
               dir_tab[DIR_W'(i)].typed, dir_tab[DIR_W'(i)].want);

    // Random phases: geometry, sender gap %, receiver stall %, command count.
    // Each phase change drains first, so the sender also waits out all results.
    run_phase(8'd8, 8'd4, 0, 0, 150);
    run_phase(8'd1, 8'd1, 69, 0, 90);
    run_phase(8'd128, 8'd64, 0, 69, 90);
    run_phase(8'd0, 8'd0, 24, 24, 60);
    run_phase(8'hFF, 8'hFF, 0, 0, 60);
    run_phase(8'd13, 8'd5, 69, 0, 110);
    run_phase(8'd37, 8'd3, 0, 69, 100);
    run_phase(8'd80, 8'd25, 24, 24, 100);
    run_phase(8'd5, 8'd2, 0, 0, 60);

    // Wait for the last results and the settle time for stray output.
    drain_results();
    if (mismatches == 0 && exp_wr == exp_rd) begin
      $display("PASS text_cell_console_writer_core");
    end else begin
      $display("FAIL text_cell_console_writer_core");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tccw_pkg.sv
design/tccw_ram.sv
design/tccw_front.sv
design/tccw_cmd_queue.sv
design/tccw_back.sv
design/text_cell_console_writer_core.sv
tb/text_cell_console_writer_core_tb.sv
